### rtl/cbpc_pkg.sv
// ----------------------------------------------------------------------------
// cbpc_pkg
// Shared types and constants of the cylinder box/point classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpc_pkg;

  // configuration register width and register indexes
  localparam int REG_BITS = 23;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS      = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_HEIGHT = 1'b1;

  // register reset values, 1.0 in unsigned Q11.12
  localparam logic [REG_BITS-1:0] RADIUS_RST      = 23'd4096;
  localparam logic [REG_BITS-1:0] HALF_HEIGHT_RST = 23'd4096;

  // query opcodes
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_BOX   = 1'b1;

  // relation codes
  typedef logic [1:0] relation_t;
  localparam relation_t REL_OUTSIDE   = 2'd0;
  localparam relation_t REL_INTERSECT = 2'd1;
  localparam relation_t REL_INSIDE    = 2'd2;
  localparam relation_t REL_INVALID   = 2'd3;

  // per-item control flags carried down the pipeline
  typedef struct packed {
    logic op;       // query opcode
    logic bad_box;  // min above max on some axis
    logic z_out;    // disjoint from the height slab
    logic in_h;     // strictly within the height slab
  } cbpc_flags_t;

endpackage

`default_nettype wire

### rtl/cbpc_prep.sv
// ----------------------------------------------------------------------------
// cbpc_prep
// Front stage logic: box checks, height tests and the near and far
// radial magnitudes of the x and y intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpc_prep
  import cbpc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         op,
  input  wire logic signed [COORD_BITS-1:0] min_x,
  input  wire logic signed [COORD_BITS-1:0] min_y,
  input  wire logic signed [COORD_BITS-1:0] min_z,
  input  wire logic signed [COORD_BITS-1:0] max_x,
  input  wire logic signed [COORD_BITS-1:0] max_y,
  input  wire logic signed [COORD_BITS-1:0] max_z,
  input  wire logic        [REG_BITS-1:0]   half_height,
  output cbpc_flags_t                       flags,
  output logic             [COORD_BITS-1:0] near_x,
  output logic             [COORD_BITS-1:0] near_y,
  output logic             [COORD_BITS-1:0] far_x,
  output logic             [COORD_BITS-1:0] far_y
);

  localparam int HW = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 2;

  logic signed [HW-1:0] z0_e;
  logic signed [HW-1:0] z1_e;
  logic signed [HW-1:0] h_e;
  logic signed [HW-1:0] nh_e;
  logic [COORD_BITS-1:0] mag_x0;
  logic [COORD_BITS-1:0] mag_x1;
  logic [COORD_BITS-1:0] mag_y0;
  logic [COORD_BITS-1:0] mag_y1;
  logic [COORD_BITS-1:0] nbox_x;
  logic [COORD_BITS-1:0] nbox_y;

  // magnitude of a signed coordinate, exact for the most negative value
  function automatic logic [COORD_BITS-1:0] mag(input logic signed [COORD_BITS-1:0] v);
    logic [COORD_BITS:0] neg;
    neg = {1'b0, ~v} + {{COORD_BITS{1'b0}}, 1'b1};
    return v[COORD_BITS-1] ? neg[COORD_BITS-1:0] : v;
  endfunction

  // nearest distance from zero to [lo, hi]
  function automatic logic [COORD_BITS-1:0] near_d(
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi,
    input logic        [COORD_BITS-1:0] mag_hi
  );
    logic [COORD_BITS-1:0] d;
    if (lo > 0) begin
      d = lo;
    end else if (hi < 0) begin
      d = mag_hi;
    end else begin
      d = '0;
    end
    return d;
  endfunction

  // sign-extended height operands
  assign z0_e = {{(HW-COORD_BITS){min_z[COORD_BITS-1]}}, min_z};
  assign z1_e = {{(HW-COORD_BITS){max_z[COORD_BITS-1]}}, max_z};
  assign h_e  = {{(HW-REG_BITS){1'b0}}, half_height};
  assign nh_e = -h_e;

  assign mag_x0 = mag(min_x);
  assign mag_x1 = mag(max_x);
  assign mag_y0 = mag(min_y);
  assign mag_y1 = mag(max_y);
  assign nbox_x = near_d(min_x, max_x, mag_x1);
  assign nbox_y = near_d(min_y, max_y, mag_y1);

  // flags per opcode
  always_comb begin
    flags.op      = op;
    flags.bad_box = (min_x > max_x) || (min_y > max_y) || (min_z > max_z);
    flags.in_h    = (z0_e > nh_e) && (z1_e < h_e);
    if (op == OP_POINT) begin
      flags.z_out = (z0_e < nh_e) || (z0_e > h_e);
    end else begin
      flags.z_out = (z1_e < nh_e) || (z0_e > h_e);
    end
  end

  // a point uses its own magnitudes as the near distance
  assign near_x = (op == OP_POINT) ? mag_x0 : nbox_x;
  assign near_y = (op == OP_POINT) ? mag_y0 : nbox_y;
  assign far_x  = (mag_x0 > mag_x1) ? mag_x0 : mag_x1;
  assign far_y  = (mag_y0 > mag_y1) ? mag_y0 : mag_y1;

endmodule

`default_nettype wire

### rtl/cbpc_eval.sv
// ----------------------------------------------------------------------------
// cbpc_eval
// Back stage logic: sums of squares against radius squared and the final
// relation code.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpc_eval
  import cbpc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire cbpc_flags_t                flags,
  input  wire logic [2*COORD_BITS-1:0]    near_x2,
  input  wire logic [2*COORD_BITS-1:0]    near_y2,
  input  wire logic [2*COORD_BITS-1:0]    far_x2,
  input  wire logic [2*COORD_BITS-1:0]    far_y2,
  input  wire logic [2*REG_BITS-1:0]      r2,
  output relation_t                       relation
);

  localparam int SQ_BITS = 2 * COORD_BITS;
  localparam int SW = ((SQ_BITS > 2*REG_BITS) ? SQ_BITS : 2*REG_BITS) + 1;

  logic [SW-1:0] near2;
  logic [SW-1:0] far2;
  logic [SW-1:0] r2_e;

  // exact sums in a common width
  assign near2 = {{(SW-SQ_BITS){1'b0}}, near_x2} + {{(SW-SQ_BITS){1'b0}}, near_y2};
  assign far2  = {{(SW-SQ_BITS){1'b0}}, far_x2} + {{(SW-SQ_BITS){1'b0}}, far_y2};
  assign r2_e  = {{(SW-2*REG_BITS){1'b0}}, r2};

  // relation decision
  always_comb begin
    if (flags.op == OP_POINT) begin
      relation = (!flags.z_out && (near2 <= r2_e)) ? REL_INSIDE : REL_OUTSIDE;
    end else if (flags.bad_box) begin
      relation = REL_INVALID;
    end else if (flags.z_out || (near2 > r2_e)) begin
      relation = REL_OUTSIDE;
    end else if (flags.in_h && (far2 < r2_e)) begin
      relation = REL_INSIDE;
    end else begin
      relation = REL_INTERSECT;
    end
  end

endmodule

`default_nettype wire

### rtl/cylinder_box_point_classifier_core.sv
// An accepted input item passes the input, magnitude, square (one 24x24
// multiply per operand) and result registers on its way to out_valid.
// Throughput: one item per cycle; all registers advance together, unless a
// held result is stalled by out_stall. Reset (synchronous, rst_n low) empties
// the pipeline and sets radius and half_height to 1.0.
// ----------------------------------------------------------------------------
// cylinder_box_point_classifier_core
// Point containment and box classification against a z-axis cylinder.
// ----------------------------------------------------------------------------
`default_nettype none

module cylinder_box_point_classifier_core
  import cbpc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [REG_BITS-1:0]          cfg_data,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic signed [COORD_BITS-1:0] in_min_x,
  input  wire logic signed [COORD_BITS-1:0] in_min_y,
  input  wire logic signed [COORD_BITS-1:0] in_min_z,
  input  wire logic signed [COORD_BITS-1:0] in_max_x,
  input  wire logic signed [COORD_BITS-1:0] in_max_y,
  input  wire logic signed [COORD_BITS-1:0] in_max_z,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output relation_t                         out_relation
);

  localparam int SQ_BITS = 2 * COORD_BITS;

  // configuration registers
  logic [REG_BITS-1:0]   radius_r;
  logic [REG_BITS-1:0]   half_height_r;
  logic [2*REG_BITS-1:0] r2_r;

  // stage 0: input register
  logic                         v0_r;
  logic                         op_r;
  logic signed [COORD_BITS-1:0] min_x_r;
  logic signed [COORD_BITS-1:0] min_y_r;
  logic signed [COORD_BITS-1:0] min_z_r;
  logic signed [COORD_BITS-1:0] max_x_r;
  logic signed [COORD_BITS-1:0] max_y_r;
  logic signed [COORD_BITS-1:0] max_z_r;

  // stage 1: magnitudes and flags
  cbpc_flags_t           flags_nxt;
  logic [COORD_BITS-1:0] near_x_nxt;
  logic [COORD_BITS-1:0] near_y_nxt;
  logic [COORD_BITS-1:0] far_x_nxt;
  logic [COORD_BITS-1:0] far_y_nxt;
  logic                  v1_r;
  cbpc_flags_t           flags1_r;
  logic [COORD_BITS-1:0] near_x_r;
  logic [COORD_BITS-1:0] near_y_r;
  logic [COORD_BITS-1:0] far_x_r;
  logic [COORD_BITS-1:0] far_y_r;

  // stage 2: squares
  logic               v2_r;
  cbpc_flags_t        flags2_r;
  logic [SQ_BITS-1:0] near_x2_r;
  logic [SQ_BITS-1:0] near_y2_r;
  logic [SQ_BITS-1:0] far_x2_r;
  logic [SQ_BITS-1:0] far_y2_r;

  // result register
  relation_t relation_nxt;
  logic      out_valid_r;
  relation_t relation_r;

  logic advance;

  // whole pipeline moves unless a held result is stalled
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // configuration writes; radius squared kept ready for the compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= RADIUS_RST;
      half_height_r <= HALF_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS:      radius_r      <= cfg_data;
        REG_HALF_HEIGHT: half_height_r <= cfg_data;
        default:         radius_r      <= radius_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= radius_r * radius_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      op_r      <= in_op;
      min_x_r   <= in_min_x;
      min_y_r   <= in_min_y;
      min_z_r   <= in_min_z;
      max_x_r   <= in_max_x;
      max_y_r   <= in_max_y;
      max_z_r   <= in_max_z;
      flags1_r  <= flags_nxt;
      near_x_r  <= near_x_nxt;
      near_y_r  <= near_y_nxt;
      far_x_r   <= far_x_nxt;
      far_y_r   <= far_y_nxt;
      flags2_r  <= flags1_r;
      near_x2_r <= near_x_r * near_x_r;
      near_y2_r <= near_y_r * near_y_r;
      far_x2_r  <= far_x_r * far_x_r;
      far_y2_r  <= far_y_r * far_y_r;
      relation_r <= relation_nxt;
    end
  end

  cbpc_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .op          (op_r),
    .min_x       (min_x_r),
    .min_y       (min_y_r),
    .min_z       (min_z_r),
    .max_x       (max_x_r),
    .max_y       (max_y_r),
    .max_z       (max_z_r),
    .half_height (half_height_r),
    .flags       (flags_nxt),
    .near_x      (near_x_nxt),
    .near_y      (near_y_nxt),
    .far_x       (far_x_nxt),
    .far_y       (far_y_nxt)
  );

  cbpc_eval #(
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .flags    (flags2_r),
    .near_x2  (near_x2_r),
    .near_y2  (near_y2_r),
    .far_x2   (far_x2_r),
    .far_y2   (far_y2_r),
    .r2       (r2_r),
    .relation (relation_nxt)
  );

  assign out_valid    = out_valid_r;
  assign out_relation = relation_r;

endmodule

`default_nettype wire

### dv/cylinder_box_point_classifier_core_test.sv
// ----------------------------------------------------------------------------
// cylinder_box_point_classifier_core_test
// Self-checking bench for the cylinder point/box classifier. A scoreboard
// predicts each relation from its own copy of radius and half height.
// Directed boundary queries run first, then random queries under several
// cylinder sizes and idle/stall mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cylinder_box_point_classifier_core_test;
  import cbpc_pkg::*;

  localparam int COORD_W   = 24;
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;
  localparam int REG_MAX   = 8388607;
  localparam int LATENCY   = 3;
  localparam int PHASE_ITEMS = 52;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   op;
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } query_t;

  // expected relations and their predictor
  class relation_tracker;
    relation_t expected_q[$];
    longint    radius_v;
    longint    half_v;
    int        mismatches;
    int        compared;
    int        seen[4];

    function new();
      radius_v = RADIUS_RST;
      half_v = HALF_HEIGHT_RST;
      mismatches = 0;
      compared = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
      if (idx == REG_RADIUS) begin
        radius_v = val;
      end else begin
        half_v = val;
      end
    endfunction

    // distance from the origin to the nearest point of an interval
    function longint axis_near(longint lo, longint hi);
      if (lo > 0) return lo;
      if (hi < 0) return -hi;
      return 0;
    endfunction

    function longint axis_far_sq(longint lo, longint hi);
      return (lo * lo > hi * hi) ? lo * lo : hi * hi;
    endfunction

    function relation_t classify_query(query_t q);
      longint x0, y0, z0, x1, y1, z1;
      longint h, r2, nx, ny, far2;
      bit     in_h;
      x0 = longint'(q.min_x);
      y0 = longint'(q.min_y);
      z0 = longint'(q.min_z);
      x1 = longint'(q.max_x);
      y1 = longint'(q.max_y);
      z1 = longint'(q.max_z);
      h = half_v;
      r2 = radius_v * radius_v;
      if (q.op == OP_POINT) begin
        if (z0 < -h || z0 > h) return REL_OUTSIDE;
        return (x0 * x0 + y0 * y0 <= r2) ? REL_INSIDE : REL_OUTSIDE;
      end
      if (x0 > x1 || y0 > y1 || z0 > z1) return REL_INVALID;
      if (z1 < -h || z0 > h) return REL_OUTSIDE;
      nx = axis_near(x0, x1);
      ny = axis_near(y0, y1);
      if (nx * nx + ny * ny > r2) return REL_OUTSIDE;
      far2 = axis_far_sq(x0, x1) + axis_far_sq(y0, y1);
      in_h = (z0 > -h) && (z1 < h);
      return (in_h && far2 < r2) ? REL_INSIDE : REL_INTERSECT;
    endfunction

    function void note_query(query_t q);
      expected_q.push_back(classify_query(q));
    endfunction

    function void check_relation(relation_t got);
      relation_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual %0d", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compared++;
      seen[want]++;
      if (got !== want) begin
        $display("%0t: relation mismatch: expected %0d, actual %0d", $time, want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_op;
  coord_t                 in_min_x, in_min_y, in_min_z;
  coord_t                 in_max_x, in_max_y, in_max_z;
  logic                   out_valid;
  logic                   out_stall;
  relation_t              out_relation;

  relation_tracker board;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cur_radius = RADIUS_RST;
  int cur_half = HALF_HEIGHT_RST;
  int settings_used = 1;

  cylinder_box_point_classifier_core #(.COORD_BITS(COORD_W)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_min_x    (in_min_x),
    .in_min_y    (in_min_y),
    .in_min_z    (in_min_z),
    .in_max_x    (in_max_x),
    .in_max_y    (in_max_y),
    .in_max_z    (in_max_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_relation(out_relation)
  );

  always #2 clk = ~clk;

  // output side stall, with an optional long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // compare every accepted result item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_relation(out_relation);
  end

  // run limit
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic query_t mk(logic op, int x0, int y0, int z0, int x1, int y1, int z1);
    query_t q;
    q.op = op;
    q.min_x = coord_t'(x0);
    q.min_y = coord_t'(y0);
    q.min_z = coord_t'(z0);
    q.max_x = coord_t'(x1);
    q.max_y = coord_t'(y1);
    q.max_z = coord_t'(z1);
    return q;
  endfunction

  function automatic coord_t rand_full();
    coord_t v;
    v = coord_t'($urandom);
    return v;
  endfunction

  function automatic coord_t rand_near(int span);
    int s;
    s = (span > COORD_MAX) ? COORD_MAX : span;
    return coord_t'($urandom_range(2 * s) - s);
  endfunction

  // ordered interval, mostly near the cylinder, sometimes anywhere
  function automatic void rand_interval(int span, output coord_t lo, output coord_t hi);
    coord_t a, b, t;
    longint top;
    int s;
    if ($urandom_range(99) < 20) begin
      a = rand_full();
      b = rand_full();
    end else begin
      s = (span > COORD_MAX) ? COORD_MAX : span;
      a = rand_near(s);
      top = longint'(a) + $urandom_range(s >> $urandom_range(8));
      b = coord_t'((top > COORD_MAX) ? COORD_MAX : top);
    end
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    lo = a;
    hi = b;
  endfunction

  // put min above max on one axis
  function automatic void break_axis(inout coord_t lo, inout coord_t hi);
    coord_t t;
    if (lo == hi) begin
      if (hi > coord_t'(COORD_MIN)) lo = hi - 1'b1;
      else hi = lo + 1'b1;
    end
    if (lo < hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
  endfunction

  function automatic query_t make_query();
    query_t q;
    int xy_span, z_span;
    xy_span = cur_radius + cur_radius / 2 + 2;
    z_span = cur_half + cur_half / 2 + 2;
    q.op = ($urandom_range(99) < 35) ? OP_POINT : OP_BOX;
    rand_interval(xy_span, q.min_x, q.max_x);
    rand_interval(xy_span, q.min_y, q.max_y);
    rand_interval(z_span, q.min_z, q.max_z);
    if (q.op == OP_POINT) begin
      if ($urandom_range(99) < 85) begin
        q.min_x = rand_near(xy_span);
        q.min_y = rand_near(xy_span);
        q.min_z = rand_near(z_span);
      end else begin
        q.min_x = rand_full();
        q.min_y = rand_full();
        q.min_z = rand_full();
      end
    end else if ($urandom_range(99) < 12) begin
      case ($urandom_range(2))
        0: break_axis(q.min_x, q.max_x);
        1: break_axis(q.min_y, q.max_y);
        default: break_axis(q.min_z, q.max_z);
      endcase
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= q.op;
    in_min_x <= q.min_x;
    in_min_y <= q.min_y;
    in_min_z <= q.min_z;
    in_max_x <= q.max_x;
    in_max_y <= q.max_y;
    in_max_z <= q.max_z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_query(q);
  endtask

  // stop offering items and let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[REG_BITS-1:0];
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_cylinder(input int unsigned radius, input int unsigned half);
    settle();
    write_reg(REG_RADIUS, radius);
    write_reg(REG_HALF_HEIGHT, half);
    cfg_we <= 1'b0;
    cur_radius = radius;
    cur_half = half;
    settings_used++;
  endtask

  initial begin
    query_t      directed[$];
    int unsigned radii[7];
    int unsigned halves[7];
    int          idle_mix[4];
    int          stall_mix[4];
    int          failed;

    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_RADIUS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_op = OP_POINT;
    in_min_x = '0;
    in_min_y = '0;
    in_min_z = '0;
    in_max_x = '0;
    in_max_y = '0;
    in_max_z = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // boundary queries against the reset cylinder of radius and half height 1.0
    directed.push_back(mk(OP_POINT, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_POINT, 4096, 0, 4096, 0, 0, 0));
    directed.push_back(mk(OP_POINT, 4097, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_POINT, 0, 0, -4097, 0, 0, 0));
    directed.push_back(mk(OP_POINT, 2896, -2896, -4096, 5, 5, 5));
    directed.push_back(mk(OP_POINT, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX));
    directed.push_back(mk(OP_POINT, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MIN));
    directed.push_back(mk(OP_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MAX));
    directed.push_back(mk(OP_BOX, -100, -100, -100, 100, 100, 100));
    // touching the side from inside, then from outside
    directed.push_back(mk(OP_BOX, -4096, 0, -10, 0, 0, 10));
    directed.push_back(mk(OP_BOX, 4096, 0, 0, 5000, 0, 0));
    // touching the top, just above it, touching the bottom from inside
    directed.push_back(mk(OP_BOX, 0, 0, 4096, 10, 10, 5000));
    directed.push_back(mk(OP_BOX, 0, 0, 4097, 10, 10, 5000));
    directed.push_back(mk(OP_BOX, -10, -10, -4096, 10, 10, 0));
    // box past the rim corner and box on the negative side
    directed.push_back(mk(OP_BOX, 3000, 3000, 0, 4000, 4000, 0));
    directed.push_back(mk(OP_BOX, -9000, 0, 0, -5000, 0, 0));
    // min above max on each axis, then a box of a single point
    directed.push_back(mk(OP_BOX, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(OP_BOX, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk(OP_BOX, 0, 0, 1, 0, 0, 0));
    directed.push_back(mk(OP_BOX, 9000, 0, 0, -9000, 0, 9000));
    directed.push_back(mk(OP_BOX, 7, 7, 7, 7, 7, 7));
    foreach (directed[i]) send_query(directed[i]);

    // degenerate cylinder with zero radius and height
    set_cylinder(0, 0);
    send_query(mk(OP_POINT, 0, 0, 0, 0, 0, 0));
    send_query(mk(OP_BOX, 0, 0, 0, 0, 0, 0));
    send_query(mk(OP_POINT, 1, 0, 0, 0, 0, 0));

    // random queries over cylinder sizes and handshake mixes
    radii[0] = 1;            halves[0] = 1;
    radii[1] = REG_MAX;      halves[1] = REG_MAX;
    radii[2] = REG_MAX;      halves[2] = 1;
    radii[3] = 1;            halves[3] = REG_MAX;
    radii[4] = $urandom_range(200000, 1);  halves[4] = $urandom_range(REG_MAX, 1);
    radii[5] = $urandom_range(REG_MAX, 1); halves[5] = $urandom_range(200000, 1);
    radii[6] = RADIUS_RST;   halves[6] = HALF_HEIGHT_RST;
    idle_mix[0] = 0;  stall_mix[0] = 0;
    idle_mix[1] = 63; stall_mix[1] = 0;
    idle_mix[2] = 0;  stall_mix[2] = 63;
    idle_mix[3] = 36; stall_mix[3] = 36;
    foreach (radii[c]) begin
      set_cylinder(radii[c], halves[c]);
      foreach (idle_mix[p]) begin
        idle_pct = idle_mix[p];
        stall_pct = stall_mix[p];
        repeat (PHASE_ITEMS) send_query(make_query());
      end
    end

    // long output hold-off while items keep coming, so the input backs up
    settle();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    repeat (48) send_query(make_query());

    settle();
    repeat (10) @(posedge clk);
    failed = board.mismatches;
    if (board.pending() != 0) begin
      $display("%0t: %0d expected relations never arrived: expected 0 left, actual %0d",
               $time, board.pending(), board.pending());
      failed++;
    end
    $display("checked %0d queries under %0d cylinder sizes and four handshake mixes",
             board.compared, settings_used);
    $display("relations seen: outside %0d, intersecting %0d, inside %0d, invalid %0d",
             board.seen[REL_OUTSIDE], board.seen[REL_INTERSECT],
             board.seen[REL_INSIDE], board.seen[REL_INVALID]);
    if (failed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### cylinder_box_point_classifier_core.f
rtl/cbpc_pkg.sv
rtl/cbpc_prep.sv
rtl/cbpc_eval.sv
rtl/cylinder_box_point_classifier_core.sv
dv/cylinder_box_point_classifier_core_test.sv
